FILE: rtl/lpbe_pkg.sv
// Shared types, codes and constants for the LED pattern and button event unit.
`timescale 1ns / 1ps

package lpbe_pkg;

  localparam int TIME_BITS = 32;
  localparam int TICK_W    = 16;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [TICK_W-1:0]    ticks_t;

  // Request codes
  localparam logic [1:0] REQ_TICK        = 2'd0;
  localparam logic [1:0] REQ_SET_PATTERN = 2'd1;
  localparam logic [1:0] REQ_INTERRUPT   = 2'd2;

  // LED patterns
  localparam logic [2:0] PAT_IDLE  = 3'd0;
  localparam logic [2:0] PAT_OFF   = 3'd1;
  localparam logic [2:0] PAT_ON    = 3'd2;
  localparam logic [2:0] PAT_SLOW  = 3'd3;
  localparam logic [2:0] PAT_FAST  = 3'd4;
  localparam logic [2:0] PAT_FLASH = 3'd5;
  localparam logic [2:0] PAT_PULSE = 3'd6;
  localparam logic [2:0] PAT_RSVD  = 3'd7;

  // Button events
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_PRESS   = 2'd1;
  localparam logic [1:0] EV_HOLD    = 2'd2;
  localparam logic [1:0] EV_RELEASE = 2'd3;

  // Register indexes
  localparam logic [2:0] CFG_MODE      = 3'd0;
  localparam logic [2:0] CFG_SLOW_ON   = 3'd1;
  localparam logic [2:0] CFG_SLOW_OFF  = 3'd2;
  localparam logic [2:0] CFG_FAST_HALF = 3'd3;
  localparam logic [2:0] CFG_FLASH_ON  = 3'd4;
  localparam logic [2:0] CFG_PULSE_ON  = 3'd5;
  localparam logic [2:0] CFG_PULSE_OFF = 3'd6;
  localparam logic [2:0] CFG_HOLD_READ = 3'd7;

  // Mode bit positions
  localparam int MODE_IN_EN   = 0;
  localparam int MODE_OUT_EN  = 1;
  localparam int MODE_INTR_EN = 2;

  localparam ticks_t IDLE_READ_TICKS = 16'd50;
  localparam ticks_t WAIT_READ_TICKS = 16'd5;

  // A period of zero counts as one tick
  function automatic ticks_t per(input ticks_t v);
    per = (v == '0) ? ticks_t'(1) : v;
  endfunction

endpackage

FILE: rtl/led_pattern_and_button_event_unit_top.sv
// LED pattern and button event unit: top level.
`timescale 1ns / 1ps

// Drives one LED and watches one button that share a pin, keeping its own
// tick time.
// Input channel (in_valid/in_ready): one beat is a tick, a set-pattern
// command or an input interrupt, with the sampled button level; any other code changes nothing.
// Result channel (out_valid/out_ready): exactly one beat per input beat,
// carrying the LED level after the item and at most one button event
// (press, hold or release) with its times.
// Configuration port (cfg_we/cfg_index/cfg_wdata): write-only, takes one
// register per cycle, to be used only while no beat is in flight.
// An accepted beat passes through the input register, then the result register, to out_*.
// Throughput: one beat per cycle while out_ready is high; the input register
// moves into the result register whenever that register is empty or its
// result is being taken.
// A stalled receiver holds the result; one more beat is parked in the input
// register, then in_ready drops until out_ready returns.
// Reset (rst_n low, synchronous) clears the tick time, idles the LED, arms
// both sides to run on the first tick and restores the register defaults.
module led_pattern_and_button_event_unit_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_req_type,
  input  logic [2:0]           in_pattern,
  input  logic                 in_button_level,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_led_level,
  output logic [1:0]           out_event_kind,
  output lpbe_pkg::time_t      out_press_time,
  output lpbe_pkg::time_t      out_hold_time,
  output lpbe_pkg::time_t      out_release_time,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  lpbe_pkg::ticks_t     cfg_wdata
);
  import lpbe_pkg::*;

  // Input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [1:0] s1_req_r;
  logic [2:0] s1_pat_r;
  logic       s1_lvl_r;
  logic       adv;

  // Result register
  logic       out_valid_r, out_valid_nxt;
  logic       out_led_r;
  logic [1:0] out_kind_r;
  time_t      out_press_r, out_hold_r, out_rel_r;

  // Configuration registers
  logic [2:0] mode_r, mode_nxt;
  ticks_t     slow_on_r, slow_on_nxt, slow_off_r, slow_off_nxt;
  ticks_t     fast_half_r, fast_half_nxt, flash_on_r, flash_on_nxt;
  ticks_t     pulse_on_r, pulse_on_nxt, pulse_off_r, pulse_off_nxt;
  ticks_t     hold_read_r, hold_read_nxt;

  // Block state
  time_t      now_r, now_nxt;
  logic [2:0] pat_r, pat_nxt;
  logic       phase_r, phase_nxt;
  logic       drive_r, drive_nxt;
  time_t      odl_r, odl_nxt;
  logic       opark_r, opark_nxt;
  logic       ostart_r, ostart_nxt;
  logic       rd_r, rd_nxt;
  time_t      idl_r, idl_nxt;
  logic       ipark_r, ipark_nxt;
  logic       istart_r, istart_nxt;
  logic       pflag_r, pflag_nxt;
  time_t      pstart_r, pstart_nxt;

  // Step scratch
  logic       run_o, run_i, o_ph;
  ticks_t     operiod, iperiod;
  logic [1:0] ev_kind;
  time_t      ev_press, ev_hold, ev_rel;

  // Advance the input register into the result register when it is free or being taken
  assign adv           = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready      = !s1_valid_r || adv;
  assign s1_valid_nxt  = (in_valid && in_ready) || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && !out_ready);

  always_comb begin
    now_nxt    = now_r;
    pat_nxt    = pat_r;
    phase_nxt  = phase_r;
    drive_nxt  = drive_r;
    odl_nxt    = odl_r;
    opark_nxt  = opark_r;
    ostart_nxt = ostart_r;
    rd_nxt     = rd_r;
    idl_nxt    = idl_r;
    ipark_nxt  = ipark_r;
    istart_nxt = istart_r;
    pflag_nxt  = pflag_r;
    pstart_nxt = pstart_r;
    run_o      = 1'b0;
    run_i      = 1'b0;
    o_ph       = 1'b0;
    operiod    = '0;
    iperiod    = '0;
    ev_kind    = EV_NONE;
    ev_press   = '0;
    ev_hold    = '0;
    ev_rel     = '0;

    mode_nxt      = mode_r;
    slow_on_nxt   = slow_on_r;
    slow_off_nxt  = slow_off_r;
    fast_half_nxt = fast_half_r;
    flash_on_nxt  = flash_on_r;
    pulse_on_nxt  = pulse_on_r;
    pulse_off_nxt = pulse_off_r;
    hold_read_nxt = hold_read_r;

    if (adv) begin
      // Decode the request; a tick advances time first
      unique case (s1_req_r)
        REQ_TICK: begin
          now_nxt = now_r + 1'b1;
          run_o   = mode_r[MODE_OUT_EN] && !opark_r && (ostart_r || (odl_r == now_nxt));
        end
        REQ_SET_PATTERN: begin
          if (mode_r[MODE_OUT_EN]) begin
            pat_nxt    = (s1_pat_r == PAT_RSVD) ? PAT_IDLE : s1_pat_r;
            phase_nxt  = 1'b0;
            opark_nxt  = 1'b0;
            ostart_nxt = 1'b1;
            run_o      = 1'b1;
          end
        end
        REQ_INTERRUPT: begin
          if (mode_r[MODE_INTR_EN] && mode_r[MODE_IN_EN]) begin
            rd_nxt     = 1'b1;
            ipark_nxt  = 1'b0;
            istart_nxt = 1'b1;
            run_i      = 1'b1;
          end
        end
        default: begin
        end
      endcase

      // Output step, then reschedule keeping phase
      if (run_o) begin
        o_ph = phase_nxt;
        case (pat_nxt)
          PAT_ON: begin
            drive_nxt = 1'b1;
            operiod   = '0;
          end
          PAT_SLOW: begin
            drive_nxt = !o_ph;
            operiod   = o_ph ? per(slow_off_r) : per(slow_on_r);
          end
          PAT_FAST: begin
            drive_nxt = !o_ph;
            operiod   = per(fast_half_r);
          end
          PAT_FLASH: begin
            drive_nxt = !o_ph;
            if (o_ph) begin
              pat_nxt = PAT_IDLE;
              operiod = '0;
            end else begin
              operiod = per(flash_on_r);
            end
          end
          PAT_PULSE: begin
            drive_nxt = !o_ph;
            operiod   = o_ph ? per(pulse_off_r) : per(pulse_on_r);
          end
          default: begin
            drive_nxt = 1'b0;
            operiod   = '0;
          end
        endcase
        phase_nxt = drive_nxt;
        if (operiod == '0) begin
          opark_nxt = 1'b1;
        end else if (ostart_nxt) begin
          odl_nxt = now_nxt + TIME_BITS'(operiod);
        end else begin
          odl_nxt = odl_r + TIME_BITS'(operiod);
        end
        ostart_nxt = 1'b0;
      end

      if (s1_req_r == REQ_TICK) begin
        run_i = mode_r[MODE_IN_EN] && !ipark_r && (istart_r || (idl_r == now_nxt));
      end

      // Input step sees the pattern as the output step left it
      if (run_i) begin
        if (!rd_nxt && (pat_nxt != PAT_IDLE)) begin
          rd_nxt  = 1'b1;
          iperiod = per(WAIT_READ_TICKS);
        end else begin
          if (s1_lvl_r) begin
            if (pflag_r) begin
              ev_kind  = EV_HOLD;
              ev_press = pstart_r;
              ev_hold  = now_nxt - pstart_r;
            end else begin
              pflag_nxt  = 1'b1;
              pstart_nxt = now_nxt;
              ev_kind    = EV_PRESS;
              ev_press   = now_nxt;
            end
          end else if (pflag_r) begin
            ev_kind   = EV_RELEASE;
            ev_press  = pstart_r;
            ev_hold   = now_nxt - pstart_r;
            ev_rel    = now_nxt;
            pflag_nxt = 1'b0;
          end
          if (pflag_nxt) begin
            rd_nxt  = (pat_nxt == PAT_IDLE);
            iperiod = per(hold_read_r);
          end else begin
            rd_nxt  = 1'b0;
            iperiod = per(IDLE_READ_TICKS);
          end
        end
        // Input periods are never zero, so this side never parks itself
        if (istart_nxt) begin
          idl_nxt = now_nxt + TIME_BITS'(iperiod);
        end else begin
          idl_nxt = idl_r + TIME_BITS'(iperiod);
        end
        istart_nxt = 1'b0;
      end
    end

    // Register writes; clearing the input or output enable parks that side
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE: begin
          mode_nxt = cfg_wdata[2:0];
          if (!cfg_wdata[MODE_IN_EN]) ipark_nxt = 1'b1;
          if (!cfg_wdata[MODE_OUT_EN]) opark_nxt = 1'b1;
        end
        CFG_SLOW_ON:   slow_on_nxt   = cfg_wdata;
        CFG_SLOW_OFF:  slow_off_nxt  = cfg_wdata;
        CFG_FAST_HALF: fast_half_nxt = cfg_wdata;
        CFG_FLASH_ON:  flash_on_nxt  = cfg_wdata;
        CFG_PULSE_ON:  pulse_on_nxt  = cfg_wdata;
        CFG_PULSE_OFF: pulse_off_nxt = cfg_wdata;
        CFG_HOLD_READ: hold_read_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= 3'b011;
      slow_on_r   <= 16'd100;
      slow_off_r  <= 16'd100;
      fast_half_r <= 16'd20;
      flash_on_r  <= 16'd10;
      pulse_on_r  <= 16'd10;
      pulse_off_r <= 16'd190;
      hold_read_r <= 16'd10;
      now_r       <= '0;
      pat_r       <= PAT_IDLE;
      phase_r     <= 1'b0;
      drive_r     <= 1'b0;
      odl_r       <= '0;
      opark_r     <= 1'b0;
      ostart_r    <= 1'b1;
      rd_r        <= 1'b1;
      idl_r       <= '0;
      ipark_r     <= 1'b0;
      istart_r    <= 1'b1;
      pflag_r     <= 1'b0;
      pstart_r    <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      mode_r      <= mode_nxt;
      slow_on_r   <= slow_on_nxt;
      slow_off_r  <= slow_off_nxt;
      fast_half_r <= fast_half_nxt;
      flash_on_r  <= flash_on_nxt;
      pulse_on_r  <= pulse_on_nxt;
      pulse_off_r <= pulse_off_nxt;
      hold_read_r <= hold_read_nxt;
      now_r       <= now_nxt;
      pat_r       <= pat_nxt;
      phase_r     <= phase_nxt;
      drive_r     <= drive_nxt;
      odl_r       <= odl_nxt;
      opark_r     <= opark_nxt;
      ostart_r    <= ostart_nxt;
      rd_r        <= rd_nxt;
      idl_r       <= idl_nxt;
      ipark_r     <= ipark_nxt;
      istart_r    <= istart_nxt;
      pflag_r     <= pflag_nxt;
      pstart_r    <= pstart_nxt;
    end
  end

  // Payload registers: load the input beat and the finished result
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req_r <= in_req_type;
      s1_pat_r <= in_pattern;
      s1_lvl_r <= in_button_level;
    end
    if (adv) begin
      out_led_r   <= drive_nxt;
      out_kind_r  <= ev_kind;
      out_press_r <= ev_press;
      out_hold_r  <= ev_hold;
      out_rel_r   <= ev_rel;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_led_level    = out_led_r;
  assign out_event_kind   = out_kind_r;
  assign out_press_time   = out_press_r;
  assign out_hold_time    = out_hold_r;
  assign out_release_time = out_rel_r;

`ifndef NO_ASSERTIONS
  // The LED drive always mirrors the pattern phase
  a_drive_phase: assert property (@(posedge clk) disable iff (!rst_n)
    drive_r == phase_r)
    else $error("LED drive and phase disagree");

  // A release closes the press: release time is press time plus hold time
  a_release_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == EV_RELEASE) |->
      out_release_time == out_press_time + out_hold_time)
    else $error("release time inconsistent with press and hold");

  // No event means all event times read zero
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == EV_NONE) |->
      (out_press_time == '0) && (out_hold_time == '0) && (out_release_time == '0))
    else $error("event times set without an event");

  // Only a mode write parks the input side
  a_ipark_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ipark_r) |-> $past(cfg_we))
    else $error("input side parked without a mode write");
`endif

endmodule

FILE: tb/lpbe_tb_pkg.sv
// Scoreboard with a cycle-free behavioral predictor of the LED pattern and button event unit.
`timescale 1ns / 1ps

package lpbe_tb_pkg;

  import lpbe_pkg::*;

  // Request code with no meaning; the block only reports the LED level for it
  localparam logic [1:0] REQ_IGNORED = 2'd3;

  typedef struct packed {
    logic       led_level;
    logic [1:0] event_kind;
    time_t      press_time;
    time_t      hold_time;
    time_t      release_time;
  } led_event_t;

  class led_event_scoreboard;

    // Register file
    logic [2:0] mode;
    ticks_t     slow_on, slow_off, fast_half, flash_on, pulse_on, pulse_off, hold_read;

    // Block state
    time_t      now_t, out_due, in_due, press_start;
    logic [2:0] pattern;
    logic       led_phase, drive, reading;
    bit         out_parked, in_parked, pressed, out_first, in_first;

    led_event_t cur;
    led_event_t awaited_events[$];
    int unsigned mismatches;

    function new();
      mode = 3'b011;
      slow_on = 16'd100; slow_off = 16'd100; fast_half = 16'd20; flash_on = 16'd10;
      pulse_on = 16'd10; pulse_off = 16'd190; hold_read = 16'd10;
      now_t = '0; out_due = '0; in_due = '0; press_start = '0;
      pattern = PAT_IDLE; led_phase = 1'b0; drive = 1'b0; reading = 1'b1;
      out_parked = 0; in_parked = 0; pressed = 0; out_first = 1; in_first = 1;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, ticks_t val);
      case (idx)
        CFG_MODE: begin
          mode = val[2:0];
          // dropping an enable parks that side until a command restarts it
          if (!mode[MODE_IN_EN]) in_parked = 1;
          if (!mode[MODE_OUT_EN]) out_parked = 1;
        end
        CFG_SLOW_ON:   slow_on = val;
        CFG_SLOW_OFF:  slow_off = val;
        CFG_FAST_HALF: fast_half = val;
        CFG_FLASH_ON:  flash_on = val;
        CFG_PULSE_ON:  pulse_on = val;
        CFG_PULSE_OFF: pulse_off = val;
        CFG_HOLD_READ: hold_read = val;
        default: ;
      endcase
    endfunction

    function ticks_t at_least_one(ticks_t v);
      if (v == '0) return ticks_t'(1);
      return v;
    endfunction

    // Returns the next period; zero parks the side
    function ticks_t led_step();
      logic ph;
      ph = led_phase;
      case (pattern)
        PAT_ON: begin
          drive = 1'b1; led_phase = 1'b1;
          return '0;
        end
        PAT_SLOW: begin
          drive = ~ph; led_phase = ~ph;
          return ph ? at_least_one(slow_off) : at_least_one(slow_on);
        end
        PAT_FAST: begin
          drive = ~ph; led_phase = ~ph;
          return at_least_one(fast_half);
        end
        PAT_FLASH: begin
          drive = ~ph; led_phase = ~ph;
          if (ph) begin
            pattern = PAT_IDLE;
            return '0;
          end
          return at_least_one(flash_on);
        end
        PAT_PULSE: begin
          drive = ~ph; led_phase = ~ph;
          return ph ? at_least_one(pulse_off) : at_least_one(pulse_on);
        end
        default: begin
          drive = 1'b0; led_phase = 1'b0;
          return '0;
        end
      endcase
    endfunction

    function ticks_t button_step(logic lvl);
      // an idle read with a pattern running only rearms the read
      if (!reading && pattern != PAT_IDLE) begin
        reading = 1'b1;
        return at_least_one(WAIT_READ_TICKS);
      end
      if (lvl) begin
        if (pressed) begin
          cur.event_kind = EV_HOLD;
          cur.press_time = press_start;
          cur.hold_time  = now_t - press_start;
        end else begin
          pressed = 1;
          press_start = now_t;
          cur.event_kind = EV_PRESS;
          cur.press_time = now_t;
        end
      end else if (pressed) begin
        cur.event_kind   = EV_RELEASE;
        cur.press_time   = press_start;
        cur.hold_time    = now_t - press_start;
        cur.release_time = now_t;
        pressed = 0;
      end
      if (pressed) begin
        reading = (pattern != PAT_IDLE) ? 1'b0 : 1'b1;
        return at_least_one(hold_read);
      end
      reading = 1'b0;
      return at_least_one(IDLE_READ_TICKS);
    endfunction

    // Advance a deadline by one period, keeping phase, or from now on a fresh start
    function void reschedule(ticks_t p, inout time_t due, inout bit parked, inout bit first);
      if (p == '0) parked = 1;
      else if (first) due = now_t + p;
      else due = due + p;
      first = 0;
    endfunction

    function void note_request(logic [1:0] req, logic [2:0] pat, logic lvl);
      cur = '0;
      case (req)
        REQ_TICK: begin
          now_t = now_t + 1;
          if (mode[MODE_OUT_EN] && !out_parked && (out_first || out_due == now_t))
            reschedule(led_step(), out_due, out_parked, out_first);
          if (mode[MODE_IN_EN] && !in_parked && (in_first || in_due == now_t))
            reschedule(button_step(lvl), in_due, in_parked, in_first);
        end
        REQ_SET_PATTERN: begin
          if (mode[MODE_OUT_EN]) begin
            pattern = (pat == PAT_RSVD) ? PAT_IDLE : pat;
            led_phase = 1'b0;
            out_parked = 0;
            out_first = 1;
            reschedule(led_step(), out_due, out_parked, out_first);
          end
        end
        REQ_INTERRUPT: begin
          if (mode[MODE_INTR_EN] && mode[MODE_IN_EN]) begin
            reading = 1'b1;
            in_parked = 0;
            in_first = 1;
            reschedule(button_step(lvl), in_due, in_parked, in_first);
          end
        end
        default: ;
      endcase
      cur.led_level = drive;
      awaited_events.push_back(cur);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(led_event_t got);
      led_event_t want;
      if (awaited_events.size() == 0) begin
        $error("result beat with no request outstanding");
        mismatches++;
        return;
      end
      want = awaited_events.pop_front();
      check_field("led_level", 32'(want.led_level), 32'(got.led_level));
      check_field("event_kind", 32'(want.event_kind), 32'(got.event_kind));
      check_field("press_time", want.press_time, got.press_time);
      check_field("hold_time", want.hold_time, got.hold_time);
      check_field("release_time", want.release_time, got.release_time);
    endfunction

    function int pending();
      return awaited_events.size();
    endfunction

  endclass

endpackage

FILE: tb/tb_top.sv
// Top-level testbench for the LED pattern and button event unit.
`timescale 1ns / 1ps

module tb_top;

  import lpbe_pkg::*;
  import lpbe_tb_pkg::*;

  // Beats per random stretch and the number of register settings walked through
  localparam int ITEMS_PER_PHASE = 90;
  localparam int LAST_PHASE      = 8;
  // Cycles without any beat on either channel before the run is declared hung
  localparam int QUIET_LIMIT     = 2000;

  // Mode masks built from the package bit positions
  localparam logic [2:0] M_IN   = 3'(1 << MODE_IN_EN);
  localparam logic [2:0] M_OUT  = 3'(1 << MODE_OUT_EN);
  localparam logic [2:0] M_INTR = 3'(1 << MODE_INTR_EN);

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_req_type = REQ_TICK;
  logic [2:0] in_pattern = PAT_IDLE;
  logic       in_button_level = 1'b0;

  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_led_level;
  logic [1:0] out_event_kind;
  time_t      out_press_time;
  time_t      out_hold_time;
  time_t      out_release_time;

  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = CFG_MODE;
  ticks_t     cfg_wdata = '0;

  led_event_scoreboard sb = new();

  // Sender idles only during some stretches; others run back to back
  bit         in_lazy = 1'b1;
  // Button level the random stimulus holds; it flips now and then so holds happen
  logic       button_now = 1'b0;
  int         quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  led_pattern_and_button_event_unit_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_pattern       (in_pattern),
    .in_button_level  (in_button_level),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_led_level    (out_led_level),
    .out_event_kind   (out_event_kind),
    .out_press_time   (out_press_time),
    .out_hold_time    (out_hold_time),
    .out_release_time (out_release_time),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // Present one request beat. Entered and left at a falling edge; valid is
  // lowered only when a gap is drawn, so a back-to-back beat keeps it high
  // with a single assignment in that time step.
  task automatic send(input logic [1:0] req, input logic [2:0] pat, input logic lvl);
    int gap;
    gap = in_lazy ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_pattern      <= pat;
    in_button_level <= lvl;
    // hold the beat until the block takes it
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_request(req, pat, lvl);
    @(negedge clk);
  endtask

  // Drop valid, drain every outstanding result, then give the pipeline spare
  // cycles so that no beat is still in flight when registers change.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all eight registers for one phase. Phase 1 uses short fixed periods
  // for the directed button sequence, phase 2 zero periods (counted as one),
  // phase 4 the largest periods, the rest draw short periods with an
  // occasional zero or maximum. The mode plan parks and restarts each side.
  task automatic program_phase(input int ph);
    ticks_t val;
    int     pick;
    for (int r = CFG_MODE; r <= CFG_HOLD_READ; r++) begin
      pick = $urandom_range(0, 99);
      if (r == CFG_MODE) begin
        case (ph)
          3:       val = ticks_t'(M_IN | M_INTR);
          4:       val = ticks_t'(M_OUT | M_INTR);
          5:       val = '0;
          7:       val = ticks_t'(M_IN | M_OUT);
          default: val = ticks_t'(M_IN | M_OUT | M_INTR);
        endcase
      end else if (ph == 1) begin
        case (r)
          CFG_SLOW_ON:   val = 16'd3;
          CFG_SLOW_OFF:  val = 16'd2;
          CFG_FAST_HALF: val = 16'd1;
          CFG_FLASH_ON:  val = 16'd2;
          CFG_PULSE_ON:  val = 16'd1;
          CFG_PULSE_OFF: val = 16'd4;
          default:       val = 16'd2;
        endcase
      end else if (ph == 2) begin
        val = '0;
      end else if (ph == 4) begin
        val = 16'hFFFF;
      end else begin
        val = (pick < 8) ? 16'h0000 : (pick < 16) ? 16'hFFFF : ticks_t'($urandom_range(1, 6));
      end
      cfg_we    <= 1'b1;
      cfg_index <= r[2:0];
      cfg_wdata <= val;
      sb.write_reg(r[2:0], val);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Random request: mostly ticks so deadlines fall due, plenty of interrupt
  // reads to catch presses early, some pattern changes and a few dead codes.
  task automatic send_random();
    int         pick;
    logic [1:0] req;
    pick = $urandom_range(0, 99);
    if (pick < 62)      req = REQ_TICK;
    else if (pick < 74) req = REQ_SET_PATTERN;
    else if (pick < 96) req = REQ_INTERRUPT;
    else                req = REQ_IGNORED;
    if ($urandom_range(0, 99) < 12) button_now = ~button_now;
    send(req, 3'($urandom_range(0, 7)), button_now);
  endtask

  // Stimulus
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, register defaults: the first tick starts both sides (the LED
    // parks idle and a held button reads as a press), interrupts are ignored
    // while rereads are disabled, then every pattern including the reserved one.
    send(REQ_TICK, PAT_IDLE, 1'b1);
    send(REQ_INTERRUPT, PAT_IDLE, 1'b0);
    send(REQ_IGNORED, PAT_RSVD, 1'b1);
    send(REQ_SET_PATTERN, PAT_ON, 1'b0);
    send(REQ_SET_PATTERN, PAT_OFF, 1'b0);
    send(REQ_SET_PATTERN, PAT_SLOW, 1'b0);
    send(REQ_TICK, PAT_IDLE, 1'b0);
    send(REQ_SET_PATTERN, PAT_FAST, 1'b1);
    send(REQ_SET_PATTERN, PAT_FLASH, 1'b0);
    send(REQ_TICK, PAT_IDLE, 1'b0);
    send(REQ_SET_PATTERN, PAT_PULSE, 1'b1);
    send(REQ_SET_PATTERN, PAT_RSVD, 1'b0);
    send(REQ_SET_PATTERN, PAT_IDLE, 1'b0);
    settle();

    for (int ph = 1; ph <= LAST_PHASE; ph++) begin
      program_phase(ph);
      if (ph == 1) begin
        // Interrupt reads walk hold and release; then a press taken with a
        // pattern running makes the next timed read a wait-and-reread.
        send(REQ_INTERRUPT, PAT_IDLE, 1'b1);
        send(REQ_TICK, PAT_IDLE, 1'b1);
        send(REQ_INTERRUPT, PAT_IDLE, 1'b0);
        send(REQ_SET_PATTERN, PAT_SLOW, 1'b0);
        send(REQ_INTERRUPT, PAT_IDLE, 1'b1);
        repeat (6) send(REQ_TICK, PAT_IDLE, 1'b1);
        button_now = 1'b1;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 16 == 0) in_lazy = ($urandom_range(0, 2) != 0);
        send_random();
      end
      settle();
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // leave room for any stray beat after the last expected one
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0)
      $display("[led_pattern_and_button_event_unit_top] OK");
    else
      $display("[led_pattern_and_button_event_unit_top] ERROR");
    $finish;
  end

  // Result side: draw a stall per beat, with stretches of none, then take the
  // beat at the rising edge where valid and ready meet.
  initial begin : result_sink
    int         stall;
    int         count;
    bit         out_lazy;
    led_event_t got;
    count = 0;
    out_lazy = 1'b1;
    forever begin
      if (count % 20 == 0) out_lazy = ($urandom_range(0, 2) != 0);
      count++;
      stall = out_lazy ? $urandom_range(0, 7) : 0;
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got = '{out_led_level, out_event_kind, out_press_time, out_hold_time, out_release_time};
      sb.check_result(got);
    end
  end

  // Watchdog: any beat on either channel clears the count
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[led_pattern_and_button_event_unit_top] ERROR");
        $finish;
      end
    end
  end

endmodule

FILE: sim.f
rtl/lpbe_pkg.sv
rtl/led_pattern_and_button_event_unit_top.sv
tb/lpbe_tb_pkg.sv
tb/tb_top.sv
